// ===== rtl/hecm_pkg.sv =====
// Package for the histogram equalized colour map block.
// Holds request codes, state types, the status struct of the tone engine and
// the fixed-point log2 used to build the threshold table. No dependencies.
package hecm_pkg;

  // Request codes carried by in_req_type
  localparam logic [1:0] REQ_CLEAR    = 2'd0;
  localparam logic [1:0] REQ_ADD      = 2'd1;
  localparam logic [1:0] REQ_FINALIZE = 2'd2;
  localparam logic [1:0] REQ_QUERY    = 2'd3;

  // Fraction bits of the log2 values behind the green thresholds
  localparam int LOG_FRAC = 44;

  // Main sequencer states
  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_ADD,
    ST_QRY,
    ST_FIN_RD,
    ST_FIN_ACC,
    ST_FIN_TONE
  } hecm_state_t;

  // Tone engine states
  typedef enum logic [1:0] {
    TN_IDLE,
    TN_DIV,
    TN_SAR,
    TN_DONE
  } tone_state_t;

  // Status returned by the tone engine
  typedef struct packed {
    logic       done;
    logic [7:0] green;
  } tone_stat_t;

  // log2(g) for 1 <= g <= 255 with LOG_FRAC fraction bits (elaboration only)
  function automatic logic [63:0] fixed_log2(input logic [7:0] g);
    logic [63:0]  m;
    logic [63:0]  res;
    logic [127:0] sq;
    int           e;
    int           i;
    e = 0;
    for (i = 1; i < 8; i++) begin
      if ((g >> i) != 8'd0) begin
        e = i;
      end
    end
    m   = 64'(g) << (63 - e);
    res = 64'(e);
    for (i = 0; i < LOG_FRAC; i++) begin
      sq  = 128'(m) * 128'(m);
      res = res << 1;
      if (sq[127]) begin
        res[0] = 1'b1;
        m      = sq[127:64];
      end else begin
        m = {sq[126:64], 1'b0};
      end
    end
    return res;
  endfunction

endpackage

// ===== rtl/hecm_cmpsub.sv =====
// Shared compare/subtract unit of the histogram equalized colour map.
// Gives a - b and the flag a >= b. Depends on nothing.
module hecm_cmpsub #(
  parameter int W = 25
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic         ge,
  output logic [W-1:0] diff
);

  logic [W:0] full;

  // Subtract with one guard bit; no borrow means a >= b
  assign full = {1'b0, a_i} - {1'b0, b_i};
  assign ge   = ~full[W];
  assign diff = full[W-1:0];

endmodule

// ===== rtl/hecm_tone.sv =====
// Tone engine: hue = floor(c * 2^HUE_BITS / total) by restoring division,
// then green by successive approximation over a 256-entry threshold table.
// Depends on hecm_pkg and hecm_cmpsub.
module hecm_tone
  import hecm_pkg::*;
#(
  parameter int COUNT_BITS = 24,
  parameter int HUE_BITS   = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [COUNT_BITS-1:0] cum_i,
  input  logic [COUNT_BITS-1:0] total_i,
  output tone_stat_t            stat
);

  localparam int UW = (COUNT_BITS > HUE_BITS) ? COUNT_BITS + 1 : HUE_BITS + 1;
  localparam int CW = $clog2(HUE_BITS + 1);

  // Smallest hue whose green level reaches g
  function automatic logic [HUE_BITS:0] thr_of(input int g);
    logic [127:0]        lhs;
    logic [127:0]        l255;
    logic [127:0]        prod;
    logic [HUE_BITS+1:0] k;
    logic [HUE_BITS+1:0] cand;
    int                  b;
    if (g == 0) begin
      return '0;
    end
    l255 = 128'(fixed_log2(8'd255));
    lhs  = 128'(fixed_log2(8'(g))) << HUE_BITS;
    if (lhs == 128'd0) begin
      return '0;
    end
    k = '0;
    for (b = HUE_BITS; b >= 0; b--) begin
      cand = k | ((HUE_BITS + 2)'(1) << b);
      prod = 128'(cand) * l255;
      if (prod < lhs) begin
        k = cand;
      end
    end
    return (HUE_BITS + 1)'(k + 1'b1);
  endfunction

  logic [HUE_BITS:0] thr_tab [256];

  // Build the threshold table at elaboration
  for (genvar gi = 0; gi < 256; gi++) begin : g_thr
    localparam logic [HUE_BITS:0] TV = thr_of(gi);
    assign thr_tab[gi] = TV;
  end

  tone_state_t           state_r, state_nxt;
  logic [COUNT_BITS-1:0] rem_r, rem_nxt;
  logic [HUE_BITS:0]     quo_r, quo_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [7:0]            g_r, g_nxt;
  logic [7:0]            cand;
  logic [UW-1:0]         op_a, op_b, diff;
  logic                  ge;

  hecm_cmpsub #(.W(UW)) u_unit (
    .a_i  (op_a),
    .b_i  (op_b),
    .ge   (ge),
    .diff (diff)
  );

  // Hold state and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= TN_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
    g_r   <= g_nxt;
  end

  // Sequence the division steps, then the green search
  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    cnt_nxt   = cnt_r;
    g_nxt     = g_r;
    cand      = g_r | 8'(8'h80 >> cnt_r);
    op_a      = '0;
    op_b      = '0;
    stat.done  = 1'b0;
    stat.green = g_r;
    case (state_r)
      TN_IDLE: begin
        if (start) begin
          rem_nxt   = cum_i;
          quo_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = TN_DIV;
        end
      end
      TN_DIV: begin
        // First step compares c itself, later ones the doubled remainder
        op_a = (cnt_r == '0) ? UW'(rem_r) : UW'({rem_r, 1'b0});
        op_b = UW'(total_i);
        rem_nxt = ge ? diff[COUNT_BITS-1:0] : op_a[COUNT_BITS-1:0];
        quo_nxt = {quo_r[HUE_BITS-1:0], ge};
        if (cnt_r == CW'(HUE_BITS)) begin
          cnt_nxt   = '0;
          g_nxt     = '0;
          state_nxt = TN_SAR;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      TN_SAR: begin
        // Keep the candidate bit when hue reaches its threshold
        op_a = UW'(quo_r);
        op_b = UW'(thr_tab[cand]);
        if (ge) begin
          g_nxt = cand;
        end
        if (cnt_r == CW'(7)) begin
          state_nxt = TN_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      TN_DONE: begin
        stat.done = 1'b1;
        state_nxt = TN_IDLE;
      end
      default: begin
        state_nxt = TN_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/histogram_equalized_colour_map_top.sv =====
// Add or query inside the bin range answers after a registered memory read, and
// outside it from the output register alone; clear and finalize walk every bin,
// finalize through the shared divide/search unit unless the histogram is empty.
// One request at a time: busy stays high until its result is shown.
// Reset runs a clearing pass over the bin memory (busy high).
// The result strobe lasts one cycle; the receiver cannot stall it.
module histogram_equalized_colour_map_top
  import hecm_pkg::*;
#(
  parameter int BINS       = 1024,
  parameter int COUNT_BITS = 24,
  parameter int HUE_BITS   = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [10:0] in_iter_count,
  output logic        out_valid,
  output logic [7:0]  out_green_level,
  output logic        out_table_ready
);

  localparam int IW = $clog2(BINS);
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

  logic [COUNT_BITS-1:0] bin_mem [BINS];
  logic [7:0]            col_mem [BINS];

  hecm_state_t           state_r, state_nxt;
  logic [IW-1:0]         idx_r, idx_nxt;
  logic [COUNT_BITS-1:0] total_r, total_nxt;
  logic [COUNT_BITS-1:0] cum_r, cum_nxt;
  logic                  ready_r, ready_nxt;
  logic                  emit_r, emit_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_green_r, out_green_nxt;
  logic                  out_ready_r;

  logic [COUNT_BITS-1:0] bin_rdata_r;
  logic [7:0]            col_rdata_r;
  logic [IW-1:0]         bin_raddr;
  logic                  bin_we;
  logic [COUNT_BITS-1:0] bin_wdata;
  logic                  col_we;
  logic [7:0]            col_wdata;

  logic [31:0]           iter_ext;
  logic [IW-1:0]         in_idx;
  logic                  in_rng;
  logic                  accept;
  logic                  last;
  logic                  adv;
  logic [COUNT_BITS:0]   cum_sum;
  logic [COUNT_BITS-1:0] cum_clamp;
  logic                  tone_start;
  tone_stat_t            tone_stat;

  assign iter_ext = 32'(in_iter_count);
  assign in_idx   = iter_ext[IW-1:0];
  assign in_rng   = iter_ext < 32'(BINS);
  assign busy     = (state_r != ST_IDLE);
  assign accept   = start & ~busy;
  assign last     = (idx_r == IW'(BINS - 1));

  assign out_valid       = out_valid_r;
  assign out_green_level = out_green_r;
  assign out_table_ready = out_ready_r;

  // Clamp the running sum at the pixel total
  assign cum_sum   = {1'b0, cum_r} + {1'b0, bin_rdata_r};
  assign cum_clamp = (cum_sum > {1'b0, total_r}) ? total_r : cum_sum[COUNT_BITS-1:0];

  hecm_tone #(
    .COUNT_BITS (COUNT_BITS),
    .HUE_BITS   (HUE_BITS)
  ) u_tone (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (tone_start),
    .cum_i   (cum_clamp),
    .total_i (total_r),
    .stat    (tone_stat)
  );

  // Bin count memory with registered read
  always_ff @(posedge clk) begin
    if (bin_we) begin
      bin_mem[idx_r] <= bin_wdata;
    end
    bin_rdata_r <= bin_mem[bin_raddr];
  end

  // Colour table memory with registered read
  always_ff @(posedge clk) begin
    if (col_we) begin
      col_mem[idx_r] <= col_wdata;
    end
    col_rdata_r <= col_mem[in_idx];
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      idx_r       <= '0;
      total_r     <= '0;
      ready_r     <= 1'b0;
      emit_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      total_r     <= total_nxt;
      ready_r     <= ready_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cum_r       <= cum_nxt;
    out_green_r <= out_green_nxt;
    out_ready_r <= ready_nxt;
  end

  // Sequence requests, sweeps and finalize steps
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    total_nxt     = total_r;
    cum_nxt       = cum_r;
    ready_nxt     = ready_r;
    emit_nxt      = emit_r;
    out_valid_nxt = 1'b0;
    out_green_nxt = 8'd0;
    bin_raddr     = (state_r == ST_IDLE) ? in_idx : idx_r;
    bin_we        = 1'b0;
    bin_wdata     = '0;
    col_we        = 1'b0;
    col_wdata     = 8'd0;
    tone_start    = 1'b0;
    adv           = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_req_type)
            REQ_CLEAR: begin
              idx_nxt   = '0;
              total_nxt = '0;
              ready_nxt = 1'b0;
              emit_nxt  = 1'b1;
              state_nxt = ST_CLR;
            end
            REQ_ADD: begin
              if (in_rng) begin
                idx_nxt   = in_idx;
                state_nxt = ST_ADD;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            REQ_FINALIZE: begin
              idx_nxt   = '0;
              cum_nxt   = '0;
              state_nxt = ST_FIN_RD;
            end
            REQ_QUERY: begin
              if (in_rng) begin
                state_nxt = ST_QRY;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_CLR: begin
        // Zero one bin per cycle
        bin_we = 1'b1;
        if (last) begin
          out_valid_nxt = emit_r;
          emit_nxt      = 1'b0;
          state_nxt     = ST_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_ADD: begin
        // Saturating increment of the bin and the total
        bin_we    = 1'b1;
        bin_wdata = (bin_rdata_r == CMAX) ? bin_rdata_r : bin_rdata_r + 1'b1;
        if (total_r != CMAX) begin
          total_nxt = total_r + 1'b1;
        end
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_QRY: begin
        out_valid_nxt = 1'b1;
        out_green_nxt = col_rdata_r;
        state_nxt     = ST_IDLE;
      end
      ST_FIN_RD: begin
        state_nxt = ST_FIN_ACC;
      end
      ST_FIN_ACC: begin
        cum_nxt = cum_clamp;
        if (total_r == '0) begin
          col_we = 1'b1;
          adv    = 1'b1;
        end else begin
          tone_start = 1'b1;
          state_nxt  = ST_FIN_TONE;
        end
      end
      ST_FIN_TONE: begin
        if (tone_stat.done) begin
          col_we    = 1'b1;
          col_wdata = tone_stat.green;
          adv       = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    // Advance to the next bin or close the finalize request
    if (adv) begin
      if (last) begin
        ready_nxt     = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end else begin
        idx_nxt   = idx_r + 1'b1;
        state_nxt = ST_FIN_RD;
      end
    end
  end

endmodule

// ===== rtl/hecm_chk.sv =====
// Port-level checker for the histogram equalized colour map, bound to the
// top level. Depends on hecm_pkg for the request codes.
module hecm_chk
  import hecm_pkg::*;
#(
  parameter int BINS = 1024
) (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_req_type,
  input logic [10:0] in_iter_count,
  input logic        out_valid,
  input logic [7:0]  out_green_level,
  input logic        out_table_ready
);

  logic acc;
  logic inr;
  logic fin_pend_r;

  assign acc = start & ~busy;
  assign inr = (32'(in_iter_count) < 32'(BINS));

  // Track a finalize request until its result shows
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_pend_r <= 1'b0;
    end else if (acc && in_req_type == REQ_FINALIZE) begin
      fin_pend_r <= 1'b1;
    end else if (out_valid) begin
      fin_pend_r <= 1'b0;
    end
  end

  // An add inside the range answers after the bin update, with zero green
  a_add_in: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_req_type == REQ_ADD && inr |=>
      !out_valid ##1 (out_valid && out_green_level == 8'd0))
    else $error("add request not answered in two cycles");

  // A query inside the range answers after the table read
  a_qry_in: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_req_type == REQ_QUERY && inr |=> !out_valid ##1 out_valid)
    else $error("query request not answered in two cycles");

  // Out-of-range add or query answers at once with zero green
  a_out_rng: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_req_type == REQ_ADD || in_req_type == REQ_QUERY) && !inr |=>
      out_valid && out_green_level == 8'd0 && !busy)
    else $error("out-of-range request mishandled");

  // Clear and finalize walk the bins before answering
  a_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_req_type == REQ_CLEAR || in_req_type == REQ_FINALIZE) |=>
      busy && !out_valid)
    else $error("sweep request answered too early");

  // A finished finalize reports a ready table and zero green
  a_fin_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && fin_pend_r |-> out_table_ready && out_green_level == 8'd0)
    else $error("finalize result carries a green level or no ready flag");

endmodule

bind histogram_equalized_colour_map_top hecm_chk #(.BINS(BINS)) u_hecm_chk (.*);
